@@ rtl/core/tgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared types and constants of the tilt gesture detector.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int THR_W    = 15;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int HOLD_W   = 16;
  localparam int MAP_W    = 18;
  localparam int DIR_W    = 3;
  localparam int TIME_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [THR_W-1:0]  TRIG_RESET = 15'd1434;
  localparam logic [THR_W-1:0]  REL_RESET  = 15'd819;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;
  localparam logic [MAP_W-1:0]  MAP_RESET  = 18'd0;

  localparam logic [DIR_W-1:0] DIR_NONE = 3'd0;
  localparam logic [DIR_W-1:0] DIR_MAX  = 3'd4;

  typedef enum logic [ADDR_W-1:0] {
    REG_BASELINE_X = 3'd0,
    REG_BASELINE_Y = 3'd1,
    REG_BASELINE_Z = 3'd2,
    REG_TRIG_THR   = 3'd3,
    REG_REL_THR    = 3'd4,
    REG_HOLD_MS    = 3'd5,
    REG_DIR_MAP    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ACTIVE = 1'b1
  } gesture_state_t;

  typedef enum logic {
    PH_HOLDING   = 1'b0,
    PH_CONFIRMED = 1'b1
  } phase_t;

  typedef struct packed {
    logic [THR_SQ_W-1:0] trig_sq;
    logic [THR_SQ_W-1:0] rel_sq;
    logic [HOLD_W-1:0]   hold_ms;
    logic [MAP_W-1:0]    dir_map;
  } tgd_cfg_t;

endpackage

@@ rtl/core/tilt_gesture_detector_unit.sv @@
// ----------------------------------------------------------------------------
// tilt_gesture_detector_unit
// Results pass the input, magnitude and result registers to the master side.
// Throughput: one sample per cycle unless the master side stalls; the gesture
// state updates once per sample.
// Reset: synchronous; gesture idle, configuration registers at reset values.
// ----------------------------------------------------------------------------
module tilt_gesture_detector_unit
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CFG_W     = (SAMPLE_BITS > MAP_W) ? SAMPLE_BITS : MAP_W,
  localparam int IN_DATA_W = ((3 * SAMPLE_BITS + TIME_W + 7) / 8) * 8,
  localparam int OUT_RAW_W = DIR_W + TIME_W,
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z, time_ms, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // read_ok
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // direction, hold_ms, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // phase
  output logic                  m_axis_tuser
);

  localparam int MAG_W = 2 * SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] baseline_x;
  logic signed [SAMPLE_BITS-1:0] baseline_y;
  logic signed [SAMPLE_BITS-1:0] baseline_z;
  tgd_cfg_t                      cfg;

  logic              s2_valid;
  logic              s2_ready;
  logic              s2_read_ok;
  logic [MAG_W-1:0]  s2_mag2;
  axis_t             s2_axis;
  logic              s2_positive;
  logic [TIME_W-1:0] s2_time_ms;

  logic [DIR_W-1:0]  out_direction;
  phase_t            out_phase;
  logic [TIME_W-1:0] out_hold_ms;

  tgd_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .baseline_x(baseline_x),
    .baseline_y(baseline_y),
    .baseline_z(baseline_z),
    .cfg       (cfg)
  );

  tgd_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAG_W      (MAG_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_read_ok (s_axis_tuser),
    .in_accel_x (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_accel_y (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_accel_z (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .in_time_ms (s_axis_tdata[3*SAMPLE_BITS+TIME_W-1:3*SAMPLE_BITS]),
    .baseline_x (baseline_x),
    .baseline_y (baseline_y),
    .baseline_z (baseline_z),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_read_ok (s2_read_ok),
    .s2_mag2    (s2_mag2),
    .s2_axis    (s2_axis),
    .s2_positive(s2_positive),
    .s2_time_ms (s2_time_ms)
  );

  tgd_track #(
    .MAG_W(MAG_W)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s2_valid     (s2_valid),
    .s2_ready     (s2_ready),
    .s2_read_ok   (s2_read_ok),
    .s2_mag2      (s2_mag2),
    .s2_axis      (s2_axis),
    .s2_positive  (s2_positive),
    .s2_time_ms   (s2_time_ms),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_direction(out_direction),
    .out_phase    (out_phase),
    .out_hold_ms  (out_hold_ms)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_hold_ms, out_direction});
  assign m_axis_tuser = out_phase;

endmodule

@@ rtl/core/tgd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tgd_cfg_regs
// Configuration registers; the squared thresholds are registered from the stored values.
// ----------------------------------------------------------------------------
module tgd_cfg_regs
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CFG_W       = MAP_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ADDR_W-1:0]             cfg_addr,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic signed [SAMPLE_BITS-1:0] baseline_x,
  output logic signed [SAMPLE_BITS-1:0] baseline_y,
  output logic signed [SAMPLE_BITS-1:0] baseline_z,
  output tgd_cfg_t                      cfg
);

  logic [THR_W-1:0]    trig_thr;
  logic [THR_W-1:0]    rel_thr;
  logic [HOLD_W-1:0]   hold_ms;
  logic [MAP_W-1:0]    dir_map;
  logic [THR_SQ_W-1:0] trig_sq;
  logic [THR_SQ_W-1:0] rel_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_x <= '0;
      baseline_y <= '0;
      baseline_z <= '0;
      trig_thr   <= TRIG_RESET;
      rel_thr    <= REL_RESET;
      hold_ms    <= HOLD_RESET;
      dir_map    <= MAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BASELINE_X: baseline_x <= cfg_data[SAMPLE_BITS-1:0];
        REG_BASELINE_Y: baseline_y <= cfg_data[SAMPLE_BITS-1:0];
        REG_BASELINE_Z: baseline_z <= cfg_data[SAMPLE_BITS-1:0];
        REG_TRIG_THR:   trig_thr   <= cfg_data[THR_W-1:0];
        REG_REL_THR:    rel_thr    <= cfg_data[THR_W-1:0];
        REG_HOLD_MS:    hold_ms    <= cfg_data[HOLD_W-1:0];
        REG_DIR_MAP:    dir_map    <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_sq <= THR_SQ_W'(TRIG_RESET) * THR_SQ_W'(TRIG_RESET);
      rel_sq  <= THR_SQ_W'(REL_RESET) * THR_SQ_W'(REL_RESET);
    end else begin
      trig_sq <= THR_SQ_W'(trig_thr) * THR_SQ_W'(trig_thr);
      rel_sq  <= THR_SQ_W'(rel_thr) * THR_SQ_W'(rel_thr);
    end
  end

  assign cfg = '{trig_sq: trig_sq, rel_sq: rel_sq, hold_ms: hold_ms, dir_map: dir_map};

endmodule

@@ rtl/core/tgd_front.sv @@
// ----------------------------------------------------------------------------
// tgd_front
// Input register, baseline removal, squared magnitude and dominant axis.
// ----------------------------------------------------------------------------
module tgd_front
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAG_W       = 2 * SAMPLE_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_read_ok,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic [TIME_W-1:0]             in_time_ms,
  input  logic signed [SAMPLE_BITS-1:0] baseline_x,
  input  logic signed [SAMPLE_BITS-1:0] baseline_y,
  input  logic signed [SAMPLE_BITS-1:0] baseline_z,
  output logic                          s2_valid,
  input  logic                          s2_ready,
  output logic                          s2_read_ok,
  output logic [MAG_W-1:0]              s2_mag2,
  output axis_t                         s2_axis,
  output logic                          s2_positive,
  output logic [TIME_W-1:0]             s2_time_ms
);

  localparam int DEV_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * DEV_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + 1;

  logic                          s1_valid;
  logic                          s1_read_ok;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;
  logic signed [SAMPLE_BITS-1:0] s1_z;
  logic [TIME_W-1:0]             s1_time_ms;

  logic              s1_load;
  logic              s2_load;
  logic [DEV_W-1:0]  dev_x;
  logic [DEV_W-1:0]  dev_y;
  logic [DEV_W-1:0]  dev_z;
  logic [DEV_W-1:0]  abs_x;
  logic [DEV_W-1:0]  abs_y;
  logic [DEV_W-1:0]  abs_z;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_z;
  logic [MAG_W-1:0]  mag2;
  axis_t             axis;
  logic [DEV_W-1:0]  abs_sel;
  logic [DEV_W-1:0]  dev_sel;
  logic              positive;

  assign s2_load  = !s2_valid || s2_ready;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  always_comb begin
    dev_x = {s1_x[SAMPLE_BITS-1], s1_x} - {baseline_x[SAMPLE_BITS-1], baseline_x};
    dev_y = {s1_y[SAMPLE_BITS-1], s1_y} - {baseline_y[SAMPLE_BITS-1], baseline_y};
    dev_z = {s1_z[SAMPLE_BITS-1], s1_z} - {baseline_z[SAMPLE_BITS-1], baseline_z};
    abs_x = dev_x[DEV_W-1] ? (~dev_x + 1'b1) : dev_x;
    abs_y = dev_y[DEV_W-1] ? (~dev_y + 1'b1) : dev_y;
    abs_z = dev_z[DEV_W-1] ? (~dev_z + 1'b1) : dev_z;
    prod_x = PROD_W'(abs_x) * PROD_W'(abs_x);
    prod_y = PROD_W'(abs_y) * PROD_W'(abs_y);
    prod_z = PROD_W'(abs_z) * PROD_W'(abs_z);
    mag2 = MAG_W'(prod_x[SQ_W-1:0]) + MAG_W'(prod_y[SQ_W-1:0]) + MAG_W'(prod_z[SQ_W-1:0]);

    axis    = AXIS_X;
    abs_sel = abs_x;
    dev_sel = dev_x;
    if (abs_y > abs_sel) begin
      axis    = AXIS_Y;
      abs_sel = abs_y;
      dev_sel = dev_y;
    end
    if (abs_z > abs_sel) begin
      axis    = AXIS_Z;
      dev_sel = dev_z;
    end
    positive = !dev_sel[DEV_W-1] && (dev_sel != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_read_ok <= in_read_ok;
      s1_x       <= in_accel_x;
      s1_y       <= in_accel_y;
      s1_z       <= in_accel_z;
      s1_time_ms <= in_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_read_ok  <= s1_read_ok;
      s2_mag2     <= mag2;
      s2_axis     <= axis;
      s2_positive <= positive;
      s2_time_ms  <= s1_time_ms;
    end
  end

endmodule

@@ rtl/core/tgd_track.sv @@
// ----------------------------------------------------------------------------
// tgd_track
// Gesture state machine, direction mapping and result register.
// ----------------------------------------------------------------------------
module tgd_track
  import tgd_pkg::*;
#(
  parameter int MAG_W = 2 * SAMPLE_BITS_DEF + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  tgd_cfg_t          cfg,
  input  logic              s2_valid,
  output logic              s2_ready,
  input  logic              s2_read_ok,
  input  logic [MAG_W-1:0]  s2_mag2,
  input  axis_t             s2_axis,
  input  logic              s2_positive,
  input  logic [TIME_W-1:0] s2_time_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIR_W-1:0]  out_direction,
  output phase_t            out_phase,
  output logic [TIME_W-1:0] out_hold_ms
);

  localparam int CMP_W = (MAG_W > THR_SQ_W) ? MAG_W : THR_SQ_W;

  gesture_state_t    state;
  gesture_state_t    state_next;
  axis_t             active_axis;
  axis_t             active_axis_next;
  logic              active_positive;
  logic              active_positive_next;
  logic [TIME_W-1:0] hold_start_ms;
  logic [TIME_W-1:0] hold_start_ms_next;
  logic              confirm_sent;
  logic              confirm_sent_next;

  logic              o_load;
  logic              step;
  logic [TIME_W-1:0] held;
  logic              below_trig;
  logic              below_rel;
  logic              emit;
  axis_t             emit_axis;
  logic              emit_pos;
  phase_t            emit_phase;
  logic [TIME_W-1:0] emit_held;
  logic [2:0]        map_sel;
  logic [DIR_W-1:0]  code;
  logic [DIR_W-1:0]  res_direction;
  phase_t            res_phase;
  logic [TIME_W-1:0] res_hold_ms;

  assign o_load   = !out_valid || out_ready;
  assign s2_ready = o_load;
  assign step     = s2_valid && o_load;

  assign held       = s2_time_ms - hold_start_ms;
  assign below_trig = CMP_W'(s2_mag2) < CMP_W'(cfg.trig_sq);
  assign below_rel  = CMP_W'(s2_mag2) < CMP_W'(cfg.rel_sq);

  always_comb begin
    state_next           = state;
    active_axis_next     = active_axis;
    active_positive_next = active_positive;
    hold_start_ms_next   = hold_start_ms;
    confirm_sent_next    = confirm_sent;
    emit                 = 1'b0;
    emit_axis            = active_axis;
    emit_pos             = active_positive;
    emit_phase           = PH_HOLDING;
    emit_held            = held;

    unique case (state)
      ST_IDLE: begin
        if (s2_read_ok && !below_trig) begin
          state_next           = ST_ACTIVE;
          active_axis_next     = s2_axis;
          active_positive_next = s2_positive;
          hold_start_ms_next   = s2_time_ms;
          confirm_sent_next    = 1'b0;
          emit                 = 1'b1;
          emit_axis            = s2_axis;
          emit_pos             = s2_positive;
          emit_held            = '0;
        end
      end
      ST_ACTIVE: begin
        if (!s2_read_ok) begin
          emit = 1'b1;
        end else if (below_rel) begin
          state_next           = ST_IDLE;
          active_axis_next     = AXIS_X;
          active_positive_next = 1'b0;
        end else begin
          emit = 1'b1;
          if (!confirm_sent && (held >= TIME_W'(cfg.hold_ms))) begin
            confirm_sent_next = 1'b1;
            emit_phase        = PH_CONFIRMED;
          end
        end
      end
      default: ;
    endcase

    map_sel = {emit_axis, emit_pos};
    code    = DIR_NONE;
    if (map_sel < 3'd6) begin
      code = cfg.dir_map[5'(map_sel) * 5'd3 +: DIR_W];
    end
    if (code > DIR_MAX) begin
      code = DIR_NONE;
    end

    if (emit && (code != DIR_NONE)) begin
      res_direction = code;
      res_phase     = emit_phase;
      res_hold_ms   = emit_held;
    end else begin
      res_direction = DIR_NONE;
      res_phase     = PH_HOLDING;
      res_hold_ms   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_axis     <= AXIS_X;
      active_positive <= 1'b0;
      hold_start_ms   <= '0;
      confirm_sent    <= 1'b0;
    end else if (step) begin
      state           <= state_next;
      active_axis     <= active_axis_next;
      active_positive <= active_positive_next;
      hold_start_ms   <= hold_start_ms_next;
      confirm_sent    <= confirm_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_direction <= res_direction;
      out_phase     <= res_phase;
      out_hold_ms   <= res_hold_ms;
    end
  end

endmodule

@@ tb/tb_tilt_gesture_detector_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tilt_gesture_detector_unit
// Streams accelerometer samples into the tilt gesture detector and checks
// every result against a cycle-free predictor of the gesture state machine.
// A short directed pass covers threshold edges, axis ties, zero deviation,
// failed reads, unmapped directions and timestamp wrap. Random phases then
// run arm/hold/confirm/release sequences mixed with noise under several
// register settings (extremes included) and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_tilt_gesture_detector_unit;
  import tgd_pkg::*;

  localparam int IN_W         = ((3 * SAMPLE_BITS_DEF + TIME_W + 7) / 8) * 8;
  localparam int OUT_W        = ((DIR_W + TIME_W + 7) / 8) * 8;
  localparam int CFG_W        = (SAMPLE_BITS_DEF > MAP_W) ? SAMPLE_BITS_DEF : MAP_W;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int RANDOM_PHASES = 10;

  typedef struct {
    logic [DIR_W-1:0]  dir;
    phase_t            ph;
    logic [TIME_W-1:0] held;
  } gesture_report_t;

  class gesture_scoreboard;
    logic signed [15:0] base_x, base_y, base_z;
    logic [THR_W-1:0]   trig_thr, rel_thr;
    logic [HOLD_W-1:0]  hold_req;
    logic [MAP_W-1:0]   dir_map;
    gesture_state_t     state;
    axis_t              axis;
    bit                 positive;
    logic [TIME_W-1:0]  start_ms;
    bit                 confirmed;
    gesture_report_t    report_q[$];
    int                 mismatches, samples, arms, confirms, releases, failed_reads;

    function new();
      base_x = '0;
      base_y = '0;
      base_z = '0;
      trig_thr = TRIG_RESET;
      rel_thr = REL_RESET;
      hold_req = HOLD_RESET;
      dir_map = MAP_RESET;
      state = ST_IDLE;
      axis = AXIS_X;
      positive = 1'b0;
      start_ms = '0;
      confirmed = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_BASELINE_X: base_x = val[15:0];
        REG_BASELINE_Y: base_y = val[15:0];
        REG_BASELINE_Z: base_z = val[15:0];
        REG_TRIG_THR:   trig_thr = val[THR_W-1:0];
        REG_REL_THR:    rel_thr = val[THR_W-1:0];
        REG_HOLD_MS:    hold_req = val[HOLD_W-1:0];
        REG_DIR_MAP:    dir_map = val[MAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function gesture_report_t direction_report(phase_t ph, logic [TIME_W-1:0] held);
      gesture_report_t r;
      logic [DIR_W-1:0] code;
      int k;
      r = '{DIR_NONE, PH_HOLDING, '0};
      if (axis > AXIS_Z) return r;
      k = int'(axis) * 2 + int'(positive);
      code = DIR_W'(dir_map >> (3 * k));
      if (code == DIR_NONE || code > DIR_MAX) return r;
      r = '{code, ph, held};
      return r;
    endfunction

    function void note_sample(bit ok, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic [TIME_W-1:0] now);
      longint dev[3];
      longint mag2;
      axis_t pick;
      logic [TIME_W-1:0] held;
      gesture_report_t r;
      r = '{DIR_NONE, PH_HOLDING, '0};
      samples++;
      if (!ok) begin
        failed_reads++;
        if (state == ST_ACTIVE) r = direction_report(PH_HOLDING, now - start_ms);
      end else begin
        dev[0] = longint'(ax) - longint'(base_x);
        dev[1] = longint'(ay) - longint'(base_y);
        dev[2] = longint'(az) - longint'(base_z);
        mag2 = dev[0] * dev[0] + dev[1] * dev[1] + dev[2] * dev[2];
        if (state == ST_IDLE) begin
          if (mag2 >= longint'(trig_thr) * longint'(trig_thr)) begin
            pick = AXIS_X;
            if (magnitude(dev[1]) > magnitude(dev[0])) pick = AXIS_Y;
            if (magnitude(dev[2]) > magnitude(dev[pick])) pick = AXIS_Z;
            state = ST_ACTIVE;
            axis = pick;
            positive = dev[pick] > 0;
            start_ms = now;
            confirmed = 1'b0;
            arms++;
            r = direction_report(PH_HOLDING, '0);
          end
        end else if (mag2 < longint'(rel_thr) * longint'(rel_thr)) begin
          state = ST_IDLE;
          axis = AXIS_X;
          positive = 1'b0;
          releases++;
        end else begin
          held = now - start_ms;
          if (!confirmed && held >= TIME_W'(hold_req)) begin
            confirmed = 1'b1;
            confirms++;
            r = direction_report(PH_CONFIRMED, held);
          end else begin
            r = direction_report(PH_HOLDING, held);
          end
        end
      end
      report_q.push_back(r);
    endfunction

    function void check_result(logic [DIR_W-1:0] dir, phase_t ph, logic [TIME_W-1:0] held);
      gesture_report_t e;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: dir=%0d phase=%0d hold_ms=%0d",
                   $time, dir, ph, held);
        return;
      end
      e = report_q.pop_front();
      if (dir !== e.dir || ph !== e.ph || held !== e.held) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: expected dir=%0d phase=%0d hold_ms=%0d, ",
                    "got dir=%0d phase=%0d hold_ms=%0d"},
                   $time, e.dir, e.ph, e.held, dir, ph, held);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // accel_x, accel_y, accel_z, time_ms, zero fill
  logic [IN_W-1:0] s_axis_tdata = '0;
  // read_ok
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // direction, hold_ms, zero fill
  logic [OUT_W-1:0] m_axis_tdata;
  // phase
  logic m_axis_tuser;

  gesture_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left = 0;
  int cycles = 0;
  int phases = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  tilt_gesture_detector_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                       s_axis_tdata[47:32], s_axis_tdata[79:48]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[2:0], phase_t'(m_axis_tuser), m_axis_tdata[34:3]);
    end
  end

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic int jitter(int q);
    if (q <= 0) return 0;
    return int'($urandom_range(2 * q, 0)) - q;
  endfunction

  function automatic logic [MAP_W-1:0] pack_map(logic [2:0] xn, logic [2:0] xp,
                                                 logic [2:0] yn, logic [2:0] yp,
                                                 logic [2:0] zn, logic [2:0] zp);
    return {zp, zn, yp, yn, xp, xn};
  endfunction

  task automatic send_sample(bit ok, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [TIME_W-1:0] stamp);
    logic [IN_W-1:0] word;
    word = {stamp, az, ay, ax};
    if ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= ok;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Offsets are deviations from the current baseline.
  task automatic send_dev(bit ok, int dx, int dy, int dz, int unsigned step);
    clock_ms += step;
    send_sample(ok, sat16(int'(sb.base_x) + dx), sat16(int'(sb.base_y) + dy),
                sat16(int'(sb.base_z) + dz), clock_ms);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                           logic [THR_W-1:0] trig, logic [THR_W-1:0] rel,
                           logic [HOLD_W-1:0] hold, logic [MAP_W-1:0] map);
    write_cfg(REG_BASELINE_X, CFG_W'(bx));
    write_cfg(REG_BASELINE_Y, CFG_W'(by));
    write_cfg(REG_BASELINE_Z, CFG_W'(bz));
    write_cfg(REG_TRIG_THR, CFG_W'(trig));
    write_cfg(REG_REL_THR, CFG_W'(rel));
    write_cfg(REG_HOLD_MS, CFG_W'(hold));
    write_cfg(REG_DIR_MAP, CFG_W'(map));
    cfg_we <= 1'b0;
    @(posedge clk);
    phases++;
  endtask

  task automatic run_gesture();
    int d[3];
    int q, amp, amp_h, a, n;
    bit neg;
    q = ((sb.trig_thr < sb.rel_thr) ? int'(sb.trig_thr) : int'(sb.rel_thr)) / 3;
    repeat ($urandom_range(3, 0))
      send_dev(1'b1, jitter(q), jitter(q), jitter(q), $urandom_range(20, 1));
    amp = int'(sb.trig_thr) + int'($urandom_range(int'(sb.trig_thr) / 2 + 100, 0));
    a = $urandom_range(2, 0);
    neg = ($urandom_range(1, 0) != 0);
    foreach (d[i]) d[i] = jitter(amp / 3);
    d[a] = neg ? -amp : amp;
    send_dev(1'b1, d[0], d[1], d[2], $urandom_range(20, 0));
    n = $urandom_range(12, 1);
    repeat (n) begin
      if ($urandom_range(9, 0) == 0) begin
        clock_ms += $urandom_range(int'(sb.hold_req) / 4 + 20, 0);
        send_sample(1'b0, 16'($urandom()), 16'($urandom()), 16'($urandom()), clock_ms);
      end else begin
        amp_h = (amp > int'(sb.rel_thr))
              ? int'(sb.rel_thr) + int'($urandom_range(amp - int'(sb.rel_thr), 0))
              : int'(sb.rel_thr);
        foreach (d[i]) d[i] = jitter(amp_h / 3);
        d[a] = neg ? -amp_h : amp_h;
        send_dev(1'b1, d[0], d[1], d[2], $urandom_range(int'(sb.hold_req) / 4 + 20, 0));
      end
    end
    if ($urandom_range(9, 0) < 7)
      send_dev(1'b1, jitter(q), jitter(q), jitter(q), $urandom_range(20, 1));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(1, 0)) clock_ms += $urandom_range(50, 0);
      else clock_ms = $urandom();
      send_sample($urandom_range(3, 0) != 0, 16'($urandom()), 16'($urandom()),
                  16'($urandom()), clock_ms);
    end
  endtask

  task automatic random_settings(int p);
    logic [15:0] b[3];
    logic [THR_W-1:0] trig, rel;
    logic [HOLD_W-1:0] hold;
    logic [MAP_W-1:0] map;
    logic [2:0] code;
    case (p)
      0: configure(16'h8000, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'hffff, 18'h3ffff);
      1: configure(16'h7fff, 16'h7fff, 16'h7fff, 15'd0, 15'd0, 16'd0, MAP_RESET);
      default: begin
        foreach (b[i]) begin
          case ($urandom_range(9, 0))
            0, 1, 2: b[i] = '0;
            3:       b[i] = 16'($urandom());
            default: b[i] = sat16(jitter(8192));
          endcase
        end
        trig = THR_W'($urandom_range(6000, 200));
        rel = ($urandom_range(9, 0) < 7)
            ? THR_W'($urandom_range(int'(trig), int'(trig) / 4))
            : THR_W'($urandom());
        hold = ($urandom_range(9, 0) == 0) ? HOLD_W'($urandom())
                                           : HOLD_W'($urandom_range(1500, 0));
        map = '0;
        for (int k = 0; k < 6; k++) begin
          code = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4, 0));
          map |= MAP_W'(code) << (3 * k);
        end
        configure(b[0], b[1], b[2], trig, rel, hold, map);
      end
    endcase
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: thresholds, ties, failed reads, unmapped codes
    configure('0, '0, '0, 15'd1000, 15'd500, 16'd100,
              pack_map(3'd1, 3'd2, 3'd4, 3'd3, 3'd0, 3'd5));
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd10);
    send_sample(1'b1, 16'd1000, 16'd0, 16'd0, 32'd20);
    send_sample(1'b1, 16'd800, 16'd0, 16'd0, 32'd50);
    send_sample(1'b0, 16'd0, 16'd0, 16'd0, 32'd130);
    send_sample(1'b1, 16'd800, 16'd0, 16'd0, 32'd130);
    send_sample(1'b1, 16'd800, 16'd0, 16'd0, 32'd140);
    send_sample(1'b1, 16'd500, 16'd0, 16'd0, 32'd150);
    send_sample(1'b1, 16'd499, 16'd0, 16'd0, 32'd160);
    send_sample(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 32'd170);
    send_sample(1'b1, -16'sd1000, -16'sd1000, 16'd0, 32'd180);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd190);
    send_sample(1'b1, 16'd0, -16'sd2000, 16'd2000, 32'd200);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd210);
    send_sample(1'b1, 16'd0, 16'd0, 16'h8000, 32'd220);
    send_sample(1'b1, 16'd0, 16'd0, 16'h8000, 32'd400);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd410);
    send_sample(1'b1, 16'd0, 16'd0, 16'h7fff, 32'd420);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd430);
    send_sample(1'b1, 16'h8000, 16'h7fff, 16'h8000, 32'd440);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'd450);
    drain();
    configure('0, '0, '0, 15'd0, 15'd0, 16'd0, pack_map(3'd1, 3'd2, 3'd4, 3'd3, 3'd4, 3'd3));
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'hffff_fff0);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'hffff_fff0);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0, 32'h0000_0010);
    send_sample(1'b0, 16'd0, 16'd0, 16'd0, 32'h0000_0020);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      clock_ms = $urandom();
      // hold off the result side so the pipeline backs up into the input
      if (p == 2 || p == 6) stall_left = 80;
      target = sb.samples + PHASE_ITEMS;
      while (sb.samples < target) begin
        if (p == 3 && sb.samples >= target - PHASE_ITEMS / 2 &&
            sb.samples < target - PHASE_ITEMS / 2 + 3)
          drain();
        if ($urandom_range(4, 0) == 0) run_noise();
        else run_gesture();
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("Run covered %0d samples over %0d register settings, %0d failed reads.",
             sb.samples, phases, sb.failed_reads);
    $display("Gestures: %0d armed, %0d confirmed, %0d released; %0d mismatches.",
             sb.arms, sb.confirms, sb.releases, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tgd_pkg.sv
rtl/core/tgd_cfg_regs.sv
rtl/core/tgd_front.sv
rtl/core/tgd_track.sv
rtl/core/tilt_gesture_detector_unit.sv
tb/tb_tilt_gesture_detector_unit.sv
